### src/plsm_pkg.sv
package plsm_pkg;

  localparam int unsigned NumChannels = 8;
  localparam int unsigned MaxPoints   = 8;
  localparam int unsigned ChW         = 3;
  localparam int unsigned PtW         = 3;
  localparam int unsigned CntW        = 4;
  localparam int unsigned AddrW       = ChW + PtW;
  localparam int unsigned Depth       = NumChannels * MaxPoints;

  typedef enum logic [1:0] {
    OP_SET_COUNT = 2'd0,
    OP_SET_POINT = 2'd1,
    OP_EVAL      = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_BAD_POINT = 2'd2,
    ST_BAD_CHAN  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SP_CHK,
    S_RD,
    S_LD,
    S_DIFF,
    S_MUL,
    S_DIV,
    S_CURVE,
    S_FIN
  } state_e;

endpackage

### src/piecewise_linear_sum_mapper.sv
// Piecewise linear sum mapper. Eight channels each hold a curve of up to eight
// Q16.16 control points in one 64-entry point memory (x and y side by side,
// registered read). Set-count and set-point items return one status transfer.
// An evaluate item reads the curve point by point until the segment is found,
// forms the slope product, and runs a one-bit-per-cycle 64-by-32 divider; the
// division is skipped when the chosen segment has equal x, and an evaluate on
// an off channel goes straight to the final state. A result that finds the
// output register still held by a stalled receiver waits in the final state.
// A new item is taken only when the previous one has finished; a finished
// result waits in the output register while the next item is taken. Writing
// the base register also restarts the running sum.
module piecewise_linear_sum_mapper
  import plsm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [2:0]         input_index_i,
  input  logic [2:0]         point_index_i,
  input  logic [3:0]         count_value_i,
  input  logic signed [31:0] x_value_i,
  input  logic signed [31:0] y_value_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic [1:0]         status_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Point memory and per-entry valid bits (an unwritten entry reads as zero).
  logic [63:0]      mem_q [Depth];
  logic [Depth-1:0] valid_q, valid_d;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [63:0]      mem_wdata, rd_raw_q;
  logic             rd_vld_q;
  logic signed [31:0] rd_x, rd_y;

  state_e state_q, state_d;
  logic [CntW-1:0] segs_q [NumChannels];
  logic [CntW-1:0] segs_d [NumChannels];
  logic signed [31:0] base_q, base_d, sum_q, sum_d;
  logic [ChW-1:0]  ch_q, ch_d;
  logic [PtW-1:0]  pi_q, pi_d;
  logic signed [31:0] xs_q, xs_d, yin_q, yin_d;
  logic            last_q, last_d, eval_q, eval_d;
  logic [CntW-1:0] n_q, n_d, idx_q, idx_d;
  logic signed [31:0] x0_q, x0_d, y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  logic [31:0]     mdy_q, mdy_d, mdxs_q, mdxs_d, dvsr_q, dvsr_d;
  logic            neg_q, neg_d, dxz_q, dxz_d;
  logic [63:0]     quo_q, quo_d;
  logic [31:0]     rem_q, rem_d;
  logic [5:0]      dcnt_q, dcnt_d;
  logic signed [31:0] cv_q, cv_d;
  logic [1:0]      stat_q, stat_d;
  logic            ov_q, ov_d;
  logic signed [31:0] oval_q, oval_d;
  logic [1:0]      ostat_q, ostat_d;

  logic accept, cfg_wr, fin_go;
  logic signed [32:0] dx, dy, dxs;
  logic [32:0] rem_sh;
  logic signed [35:0] yq;
  logic signed [32:0] acc;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = paddr[2] ? 32'd0 : base_q;
  assign out_valid_o = ov_q;
  assign value_o  = oval_q;
  assign status_o = ostat_q;
  assign rd_x     = rd_vld_q ? rd_raw_q[63:32] : 32'sd0;
  assign rd_y     = rd_vld_q ? rd_raw_q[31:0]  : 32'sd0;
  assign fin_go   = !(eval_q && !last_q) ? (!ov_q || !out_stall_i) : 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_e'(op_i))
            OP_SET_COUNT: state_d = S_FIN;
            OP_SET_POINT: begin
              if ({1'b0, point_index_i} >= segs_q[input_index_i] || point_index_i == '0) begin
                state_d = S_FIN;
              end else begin
                state_d = S_SP_CHK;
              end
            end
            OP_EVAL: state_d = (segs_q[input_index_i] >= CntW'(2)) ? S_RD : S_FIN;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SP_CHK: state_d = S_FIN;
      S_RD:     state_d = S_LD;
      S_LD: begin
        if (idx_q == '0) begin
          state_d = S_RD;
        end else if ((idx_q + CntW'(1)) < n_q && xs_q > rd_x) begin
          state_d = S_RD;
        end else begin
          state_d = S_DIFF;
        end
      end
      S_DIFF:  state_d = S_MUL;
      S_MUL:   state_d = dxz_q ? S_CURVE : S_DIV;
      S_DIV:   state_d = (dcnt_q == 6'd63) ? S_CURVE : S_DIV;
      S_CURVE: state_d = S_FIN;
      S_FIN:   state_d = fin_go ? S_IDLE : S_FIN;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    segs_d = segs_q;
    base_d = base_q;
    sum_d  = sum_q;
    ch_d = ch_q; pi_d = pi_q; xs_d = xs_q; yin_d = yin_q;
    last_d = last_q; eval_d = eval_q; n_d = n_q; idx_d = idx_q;
    x0_d = x0_q; y0_d = y0_q; x1_d = x1_q; y1_d = y1_q;
    mdy_d = mdy_q; mdxs_d = mdxs_q; dvsr_d = dvsr_q;
    neg_d = neg_q; dxz_d = dxz_q;
    quo_d = quo_q; rem_d = rem_q; dcnt_d = dcnt_q;
    cv_d = cv_q; stat_d = stat_q;
    ov_d = ov_q; oval_d = oval_q; ostat_d = ostat_q;
    valid_d = valid_q;
    mem_we = 1'b0;
    mem_waddr = {ch_q, pi_q};
    mem_wdata = {xs_q, yin_q};
    mem_raddr = {ch_q, idx_q[PtW-1:0]};
    dx = 33'(x1_q) - 33'(x0_q);
    dy = 33'(y1_q) - 33'(y0_q);
    dxs = 33'(xs_q) - 33'(x0_q);
    rem_sh = {rem_q, quo_q[63]};
    yq = 36'(y0_q) + (neg_q ? -$signed({2'b00, quo_q[33:0]}) : $signed({2'b00, quo_q[33:0]}));
    acc = 33'(sum_q) + 33'(cv_q);

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    if (cfg_wr && !paddr[2]) begin
      base_d = pwdata;
      sum_d  = pwdata;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ch_d = input_index_i; pi_d = point_index_i;
          xs_d = x_value_i; yin_d = y_value_i; last_d = last_i;
          eval_d = (op_e'(op_i) == OP_EVAL);
          n_d = segs_q[input_index_i];
          idx_d = '0;
          cv_d = '0;
          stat_d = ST_OK;
          mem_raddr = {input_index_i, 3'(point_index_i - 3'd1)};
          unique case (op_e'(op_i))
            OP_SET_COUNT: begin
              if (count_value_i == CntW'(1) || count_value_i > CntW'(MaxPoints)) begin
                stat_d = ST_BAD_COUNT;
              end else begin
                segs_d[input_index_i] = count_value_i;
              end
            end
            OP_SET_POINT: begin
              if ({1'b0, point_index_i} >= segs_q[input_index_i]) begin
                stat_d = ST_BAD_POINT;
              end else if (point_index_i == '0) begin
                mem_we = 1'b1;
                mem_waddr = {input_index_i, point_index_i};
                mem_wdata = {x_value_i, y_value_i};
              end
            end
            default: ;
          endcase
        end
      end
      // Previous point's x has been read; enforce strictly rising x.
      S_SP_CHK: begin
        if (xs_q <= rd_x) begin
          stat_d = ST_BAD_POINT;
        end else begin
          mem_we = 1'b1;
        end
      end
      S_RD: ;
      // Segment search: shift the window one point per read.
      S_LD: begin
        if (idx_q == '0) begin
          x0_d = rd_x; y0_d = rd_y;
        end else begin
          if (idx_q != CntW'(1)) begin
            x0_d = x1_q; y0_d = y1_q;
          end
          x1_d = rd_x; y1_d = rd_y;
        end
        idx_d = idx_q + CntW'(1);
      end
      S_DIFF: begin
        neg_d  = ((dy < 0) != (dxs < 0)) != (dx < 0);
        mdy_d  = dy[32] ? 32'(-dy) : dy[31:0];
        mdxs_d = dxs[32] ? 32'(-dxs) : dxs[31:0];
        dvsr_d = dx[32] ? 32'(-dx) : dx[31:0];
        dxz_d  = (dx == '0);
      end
      S_MUL: begin
        quo_d  = 64'(mdy_q) * 64'(mdxs_q);
        rem_d  = '0;
        dcnt_d = '0;
        if (dxz_q) begin
          cv_d = y0_q;
        end
      end
      // Restoring division, one quotient bit per cycle.
      S_DIV: begin
        if (rem_sh >= {1'b0, dvsr_q}) begin
          rem_d = 32'(rem_sh - {1'b0, dvsr_q});
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = rem_sh[31:0];
          quo_d = {quo_q[62:0], 1'b0};
        end
        dcnt_d = dcnt_q + 6'd1;
      end
      S_CURVE: begin
        if (!dxz_q) begin
          if (quo_q > 64'h2_0000_0000) begin
            cv_d = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
          end else if (yq > 36'sh0_7fff_ffff) begin
            cv_d = 32'sh7fff_ffff;
          end else if (yq < -36'sh0_8000_0000) begin
            cv_d = 32'sh8000_0000;
          end else begin
            cv_d = yq[31:0];
          end
        end
      end
      // Accumulate evaluate results; hand the sum (last item) or a status to the output register.
      S_FIN: begin
        if (fin_go) begin
          if (eval_q) begin
            if (acc > 33'sh0_7fff_ffff) begin
              sum_d = 32'sh7fff_ffff;
            end else if (acc < -33'sh0_8000_0000) begin
              sum_d = 32'sh8000_0000;
            end else begin
              sum_d = acc[31:0];
            end
            if (last_q) begin
              ov_d = 1'b1;
              oval_d = sum_d;
              ostat_d = stat_q;
              sum_d = base_q;
            end
          end else begin
            ov_d = 1'b1;
            oval_d = '0;
            ostat_d = stat_q;
          end
        end
      end
      default: ;
    endcase

    if (mem_we) begin
      valid_d[mem_waddr] = 1'b1;
    end
  end

  // Point memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_raw_q <= mem_q[mem_raddr];
  end

  // Control state and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      segs_q   <= '{default: '0};
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      base_q   <= '0;
      sum_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      segs_q   <= segs_d;
      valid_q  <= valid_d;
      rd_vld_q <= valid_q[mem_raddr];
      base_q   <= base_d;
      sum_q    <= sum_d;
      ov_q     <= ov_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ch_q <= ch_d; pi_q <= pi_d; xs_q <= xs_d; yin_q <= yin_d;
    last_q <= last_d; eval_q <= eval_d; n_q <= n_d; idx_q <= idx_d;
    x0_q <= x0_d; y0_q <= y0_d; x1_q <= x1_d; y1_q <= y1_d;
    mdy_q <= mdy_d; mdxs_q <= mdxs_d; dvsr_q <= dvsr_d;
    neg_q <= neg_d; dxz_q <= dxz_d;
    quo_q <= quo_d; rem_q <= rem_d; dcnt_q <= dcnt_d;
    cv_q <= cv_d; stat_q <= stat_d;
    oval_q <= oval_d; ostat_q <= ostat_d;
  end

endmodule
